[rtl/ptm_pkg.sv]
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and codes for the predecessor take multiset block.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // fixed port widths of the beat fields
    localparam int PORT_VALUE_WIDTH = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TAKE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;   // register value <= key into le flag
        logic ins_en;   // shift right above the insert point
        logic take_en;  // shift left from the removed cell
    } cell_ctrl_t;

endpackage

[rtl/predecessor_take_multiset.sv]
// sequencing: each item spends a compare cycle and then a shift cycle in the cell chain;
//   m_valid is registered at the end of the shift cycle, and the next item can be
//   accepted in that same shift cycle
// reset: synchronous active-low aresetn empties the store at once, no sweep
// an output beat that waits for m_ready stalls the shift cycle only
// ----------------------------------------------------------------------------
// predecessor_take_multiset
// Bounded multiset kept sorted in a chain of cells. Insert adds a value,
// take removes and returns the largest stored value not above a limit.
// ----------------------------------------------------------------------------
module predecessor_take_multiset #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input beats
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic [ptm_pkg::PORT_VALUE_WIDTH-1:0]   s_value,
    // result beats
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic [ptm_pkg::PORT_VALUE_WIDTH-1:0]   m_taken_value
);

    localparam int PW = ptm_pkg::PORT_VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                 state_reg;
    ptm_pkg::op_t           op_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic                   m_valid_reg;
    ptm_pkg::status_t       m_status_reg;
    logic [PW-1:0]          m_taken_reg;

    // cell chain wiring
    logic [VALUE_WIDTH-1:0] cell_val   [CAPACITY];
    logic                   cell_valid [CAPACITY];
    logic                   cell_le    [CAPACITY];
    logic                   right_le   [CAPACITY];

    ptm_pkg::cell_ctrl_t    ctrl;
    logic [VALUE_WIDTH-1:0] key_in;
    logic [VALUE_WIDTH+PW-1:0] key_wide;
    logic [VALUE_WIDTH-1:0] pick;
    logic [VALUE_WIDTH+PW-1:0] pick_wide;
    logic                   full;
    logic                   found;
    logic                   out_free;
    logic                   commit;
    logic                   accept;

    // value taken modulo 2^VALUE_WIDTH, zero extended when wider than the port
    assign key_wide = {{VALUE_WIDTH{1'b0}}, s_value};
    assign key_in   = key_wide[VALUE_WIDTH-1:0];

    // occupied cells form a prefix, so the last cell tells full
    assign full  = cell_valid[CAPACITY-1];
    // sorted ascending: le flags form a prefix, first cell tells any hit
    assign found = cell_le[0];

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_UPD) && out_free;
    assign s_ready  = (state_reg == S_IDLE) || commit;
    assign accept   = s_valid && s_ready;

    assign ctrl.cmp_en  = (state_reg == S_CMP);
    assign ctrl.ins_en  = commit && (op_reg == ptm_pkg::OP_INSERT) && !full;
    assign ctrl.take_en = commit && (op_reg == ptm_pkg::OP_TAKE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_WIDTH-1:0] lv;
            logic                   lval;
            logic                   lle;
            logic [VALUE_WIDTH-1:0] rv;
            logic                   rval;

            if (gi == 0) begin : g_first
                // the chain head sees an always-matching left side
                assign lv   = key_reg;
                assign lval = 1'b1;
                assign lle  = 1'b1;
            end else begin : g_mid_l
                assign lv   = cell_val[gi-1];
                assign lval = cell_valid[gi-1];
                assign lle  = cell_le[gi-1];
            end

            if (gi == CAPACITY-1) begin : g_last
                // past the tail: empty, never matching
                assign rv           = key_reg;
                assign rval         = 1'b0;
                assign right_le[gi] = 1'b0;
            end else begin : g_mid_r
                assign rv           = cell_val[gi+1];
                assign rval         = cell_valid[gi+1];
                assign right_le[gi] = cell_le[gi+1];
            end

            ptm_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .key         (key_reg),
                .left_val    (lv),
                .left_valid  (lval),
                .left_le     (lle),
                .right_val   (rv),
                .right_valid (rval),
                .right_le    (right_le[gi]),
                .val         (cell_val[gi]),
                .valid       (cell_valid[gi]),
                .le          (cell_le[gi])
            );
        end
    endgenerate

    // the predecessor sits at the single le-to-not-le boundary; and-or select
    always_comb begin
        pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_le[i] && !right_le[i]) begin
                pick = pick | cell_val[i];
            end
        end
    end

    assign pick_wide = {{PW{1'b0}}, pick};

    // sequencer: idle -> compare -> shift, next beat taken on the shift cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (commit) begin
                        state_reg <= accept ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // beat payload and result payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= ptm_pkg::op_t'(s_opcode);
            key_reg <= key_in;
        end
        if (commit) begin
            if (op_reg == ptm_pkg::OP_INSERT) begin
                m_status_reg <= full ? ptm_pkg::ST_FULL : ptm_pkg::ST_INSERTED;
                m_taken_reg  <= '0;
            end else begin
                m_status_reg <= found ? ptm_pkg::ST_FOUND : ptm_pkg::ST_NONE;
                m_taken_reg  <= found ? pick_wide[PW-1:0] : '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_taken_value = m_taken_reg;

endmodule

[rtl/ptm_cell.sv]
// ----------------------------------------------------------------------------
// ptm_cell
// One slot of the sorted chain: holds a value, an occupied bit and the
// registered result of comparing against the broadcast key.
// ----------------------------------------------------------------------------
module ptm_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ptm_pkg::cell_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0]  key,
    // left neighbor (lower index, smaller values)
    input  logic [VALUE_WIDTH-1:0]  left_val,
    input  logic                    left_valid,
    input  logic                    left_le,
    // right neighbor (higher index, larger values)
    input  logic [VALUE_WIDTH-1:0]  right_val,
    input  logic                    right_valid,
    input  logic                    right_le,
    output logic [VALUE_WIDTH-1:0]  val,
    output logic                    valid,
    output logic                    le
);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   valid_reg;
    logic                   le_reg;

    // occupied bit and compare flag are control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
        end else begin
            if (ctrl.cmp_en) begin
                le_reg <= valid_reg && (val_reg <= key);
            end
            if (ctrl.ins_en && !le_reg) begin
                valid_reg <= valid_reg | left_valid;
            end else if (ctrl.take_en && !right_le) begin
                valid_reg <= right_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && !le_reg) begin
            val_reg <= left_le ? key : left_val;
        end else if (ctrl.take_en && !right_le) begin
            val_reg <= right_val;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;
    assign le    = le_reg;

endmodule

[rtl/ptm_checker.sv]
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks for the predecessor take multiset block.
// ----------------------------------------------------------------------------
module ptm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_taken_value
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_taken_value))
        else $error("result beat changed while stalled");

    // only a found take carries a value
    a_taken_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ptm_pkg::ST_FOUND) |-> m_taken_value == '0)
        else $error("nonzero taken value without found status");

    // compare cycle follows every accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during compare cycle");

    // a result beat is expected once the compare and shift cycles of an accepted beat are over
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##3 m_valid)
        else $error("no result two cycles after input beat");

endmodule

bind predecessor_take_multiset ptm_checker u_ptm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_taken_value (m_taken_value)
);

[verif/tb_predecessor_take_multiset.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_predecessor_take_multiset
// Drives insert and take beats into the sorted multiset and checks every
// result beat against a bench copy of the store or a typed table answer.
// A short directed table comes first, then random beats that fill the store
// past full and drain it again, under three patterns of idling on both sides.
// ----------------------------------------------------------------------------
module tb_predecessor_take_multiset;

    localparam int          CAP          = 256;
    localparam int          VW           = 32;
    localparam logic [31:0] MAXV         = 32'hFFFF_FFFF;
    localparam int          DIR_ROWS     = 19;
    localparam int          RAND_SEGS    = 6;
    localparam int          RAND_ITEMS   = 1650;
    localparam int          TOTAL_ITEMS  = DIR_ROWS + RAND_ITEMS;
    // watchdog limit, many times the slowest correct run
    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam int          DRAIN_LIMIT  = 100_000;
    localparam int          TAIL_CYCLES  = 16;

    // one result beat as the checker sees it
    typedef struct {
        ptm_pkg::status_t st;
        logic [31:0]      tv;
    } result_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct {
        ptm_pkg::op_t     op;
        logic [31:0]      value;
        bit               typed;
        ptm_pkg::status_t st;
        logic [31:0]      tv;
    } dir_row_t;

    // how the random part leans between inserts and takes
    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    // clock, reset and dut ports; the driven ones are known from time zero
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_opcode      = 1'b0;
    logic [31:0] s_value       = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_taken_value;

    // typed answer that travels alongside the payload of a directed beat
    bit               row_typed  = 1'b0;
    ptm_pkg::status_t row_status = ptm_pkg::ST_INSERTED;
    logic [31:0]      row_taken  = '0;

    // bench copy of the store: cells, occupancy, count
    logic [VW-1:0] mdl_value [CAP];
    bit            mdl_used  [CAP];
    int            mdl_count = 0;

    result_t pending_results [$];
    int      fail_count      = 0;
    int      beats_sent      = 0;
    int      send_idle_pct   = 0;
    int      recv_idle_pct   = 0;

    // directed table: empty store first, then extremes, duplicates and the
    // inclusive all-ones limit
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ptm_pkg::OP_TAKE,   MAXV,          1'b1, ptm_pkg::ST_NONE, 32'h0},  // empty store
        '{ptm_pkg::OP_TAKE,   32'h0,         1'b1, ptm_pkg::ST_NONE, 32'h0},
        '{ptm_pkg::OP_INSERT, 32'h0,         1'b1, ptm_pkg::ST_INSERTED, 32'h0},  // lowest
        '{ptm_pkg::OP_INSERT, MAXV,          1'b1, ptm_pkg::ST_INSERTED, 32'h0},  // highest
        '{ptm_pkg::OP_INSERT, 32'd1000,      1'b1, ptm_pkg::ST_INSERTED, 32'h0},
        '{ptm_pkg::OP_INSERT, 32'd1000,      1'b1, ptm_pkg::ST_INSERTED, 32'h0},  // copy
        '{ptm_pkg::OP_INSERT, 32'h8000_0000, 1'b1, ptm_pkg::ST_INSERTED, 32'h0},
        '{ptm_pkg::OP_TAKE,   32'd999,       1'b0, ptm_pkg::ST_NONE, 32'h0},  // finds the zero
        '{ptm_pkg::OP_TAKE,   32'd999,       1'b0, ptm_pkg::ST_NONE, 32'h0},  // nothing below
        '{ptm_pkg::OP_TAKE,   32'd1000,      1'b0, ptm_pkg::ST_NONE, 32'h0},  // limit = value
        '{ptm_pkg::OP_TAKE,   32'd1000,      1'b0, ptm_pkg::ST_NONE, 32'h0},  // second copy
        '{ptm_pkg::OP_TAKE,   32'd1000,      1'b0, ptm_pkg::ST_NONE, 32'h0},
        '{ptm_pkg::OP_TAKE,   MAXV - 32'd1,  1'b0, ptm_pkg::ST_NONE, 32'h0},
        '{ptm_pkg::OP_TAKE,   MAXV,          1'b0, ptm_pkg::ST_NONE, 32'h0},  // all-ones limit
        '{ptm_pkg::OP_TAKE,   MAXV,          1'b0, ptm_pkg::ST_NONE, 32'h0},  // empty again
        '{ptm_pkg::OP_INSERT, 32'h5555_5555, 1'b1, ptm_pkg::ST_INSERTED, 32'h0},
        '{ptm_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b1, ptm_pkg::ST_INSERTED, 32'h0},
        '{ptm_pkg::OP_TAKE,   32'hAAAA_AAA9, 1'b0, ptm_pkg::ST_NONE, 32'h0},  // under the top
        '{ptm_pkg::OP_TAKE,   MAXV,          1'b0, ptm_pkg::ST_NONE, 32'h0}
    };

    // random part: fill past full and drain twice
    mix_t seg_mix [RAND_SEGS] = '{MIX_BALANCED, MIX_FILL, MIX_DRAIN,
                                  MIX_BALANCED, MIX_FILL, MIX_DRAIN};
    int   seg_len [RAND_SEGS] = '{150, 320, 320, 200, 320, 340};

    predecessor_take_multiset #(
        .CAPACITY    (CAP),
        .VALUE_WIDTH (VW)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_taken_value (m_taken_value)
    );

    always #2 aclk = ~aclk;

    // apply one beat to the bench copy of the store and return its result
    function automatic result_t multiset_step(input ptm_pkg::op_t op, input logic [31:0] v);
        result_t       r;
        int            where;
        logic [VW-1:0] best;
        r.st  = ptm_pkg::ST_FULL;
        r.tv  = '0;
        where = -1;
        best  = '0;
        if (op == ptm_pkg::OP_INSERT) begin
            // lowest free cell takes the value, nothing changes when full
            if (mdl_count < CAP) begin
                for (int i = 0; i < CAP; i++) begin
                    if (!mdl_used[i]) begin
                        where = i;
                        break;
                    end
                end
                mdl_used[where]  = 1'b1;
                mdl_value[where] = v;
                mdl_count++;
                r.st = ptm_pkg::ST_INSERTED;
            end
        end else begin
            // largest value not above the limit, lowest cell among equal copies
            for (int i = 0; i < CAP; i++) begin
                if (mdl_used[i] && mdl_value[i] <= v) begin
                    if (where < 0 || mdl_value[i] > best) begin
                        where = i;
                        best  = mdl_value[i];
                    end
                end
            end
            if (where >= 0) begin
                mdl_used[where] = 1'b0;
                mdl_count--;
                r.st = ptm_pkg::ST_FOUND;
                r.tv = best;
            end else begin
                r.st = ptm_pkg::ST_NONE;
            end
        end
        return r;
    endfunction

    // random beat: opcode leans with the mix, value is wide random, small,
    // an extreme, or a neighbor of something already stored
    task automatic random_item(input mix_t mix, output ptm_pkg::op_t op,
                               output logic [31:0] v);
        int ins_pct;
        int pick;
        int idx;
        case (mix)
            MIX_FILL:  ins_pct = 95;
            MIX_DRAIN: ins_pct = 5;
            default:   ins_pct = 50;
        endcase
        op   = ($urandom_range(0, 99) < ins_pct) ? ptm_pkg::OP_INSERT : ptm_pkg::OP_TAKE;
        pick = $urandom_range(0, 3);
        case (pick)
            0: v = $urandom;
            1: v = $urandom_range(0, 15);
            2: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h0;
                    1:       v = 32'h1;
                    2:       v = MAXV;
                    3:       v = MAXV - 32'd1;
                    4:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            default: begin
                if (mdl_count > 0) begin
                    idx = $urandom_range(0, CAP - 1);
                    while (!mdl_used[idx]) idx = $urandom_range(0, CAP - 1);
                    v = mdl_value[idx] + $urandom_range(0, 2) - 32'd1;
                end else begin
                    v = $urandom;
                end
            end
        endcase
    endtask

    // present one beat and hold it until accepted
    task automatic send_beat(input ptm_pkg::op_t op, input logic [31:0] v, input bit typed,
                             input ptm_pkg::status_t st, input logic [31:0] tv);
        // idling pattern follows how far the run has got
        if (beats_sent < TOTAL_ITEMS / 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 88;
        end else if (beats_sent < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 12;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_value    <= v;
        row_typed  <= typed;
        row_status <= st;
        row_taken  <= tv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // receiver stalls at random, one decision per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // input beats feed the bench store, result beats are checked in order;
    // input side goes first so a same-edge result still finds its entry
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = multiset_step(ptm_pkg::op_t'(s_opcode), s_value);
                if (row_typed) begin
                    want.st = row_status;
                    want.tv = row_taken;
                end
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d taken_value %0h",
                           m_status, m_taken_value);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, m_status);
                        fail_count++;
                    end
                    if (m_taken_value !== want.tv) begin
                        $error("taken_value: expected %0h, actual %0h",
                               want.tv, m_taken_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        ptm_pkg::op_t op;
        logic [31:0]  v;
        int           drain_wait;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_beat(dir_table[r].op, dir_table[r].value, dir_table[r].typed,
                      dir_table[r].st, dir_table[r].tv);
        end

        // random segments
        for (int s = 0; s < RAND_SEGS; s++) begin
            for (int k = 0; k < seg_len[s]; k++) begin
                random_item(seg_mix[s], op, v);
                send_beat(op, v, 1'b0, ptm_pkg::ST_INSERTED, 32'h0);
            end
        end
        s_valid <= 1'b0;

        // let every result come back, then wait quietly for strays
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("** predecessor_take_multiset: PASSED **");
        end else begin
            $display("** predecessor_take_multiset: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("** predecessor_take_multiset: FAILED **");
        $finish;
    end

endmodule

[predecessor_take_multiset.f]
rtl/ptm_pkg.sv
rtl/ptm_cell.sv
rtl/predecessor_take_multiset.sv
rtl/ptm_checker.sv
verif/tb_predecessor_take_multiset.sv
